@@ hw/rtl/cma_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar minutes adder.
package cma_pkg;

   // Field widths
   localparam int unsigned ADD_W   = 14;
   localparam int unsigned YEAR_W  = 2;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned WDAY_W  = 3;

   // Calendar limits
   localparam logic [ADD_W-1:0]   HOUR_MINUTES = ADD_W'(60);
   localparam logic [MIN_W:0]     MINUTE_MAX   = (MIN_W+1)'(59);
   localparam logic [HOUR_W:0]    HOUR_MAX     = (HOUR_W+1)'(23);
   localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR    = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN    = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP    = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV    = MONTH_W'(11);
   localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
   localparam logic [YEAR_W-1:0]  LEAP_YEAR    = YEAR_W'(0);
   localparam logic [DAY_W-1:0]   FIRST_DAY    = DAY_W'(1);

   typedef struct packed {
      logic [ADD_W-1:0]   minutes_to_add;
      logic [YEAR_W-1:0]  year_in;
      logic [MONTH_W-1:0] month_in;
      logic [DAY_W-1:0]   day_in;
      logic [HOUR_W-1:0]  hour_in;
      logic [MIN_W-1:0]   minute_in;
      logic [SEC_W-1:0]   second_in;
      logic [WDAY_W-1:0]  weekday_in;
   } cma_req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year_out;
      logic [MONTH_W-1:0] month_out;
      logic [DAY_W-1:0]   day_out;
      logic [HOUR_W-1:0]  hour_out;
      logic [MIN_W-1:0]   minute_out;
      logic [SEC_W-1:0]   second_out;
      logic [WDAY_W-1:0]  weekday_out;
   } cma_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HOURS,
      ST_MINUTES,
      ST_DONE
   } cma_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step_hour;
      logic step_minute;
   } cma_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rem_ge_hour;
      logic rem_zero;
   } cma_status_type;

   // Length of a month; unknown month codes count as 31 days
   function automatic logic [DAY_W-1:0] cma_month_days(logic [YEAR_W-1:0]  yr,
                                                       logic [MONTH_W-1:0] mo);
      logic [DAY_W-1:0] n;
      unique case (mo) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = DAY_W'(30);
         MONTH_FEB: n = (yr == LEAP_YEAR) ? DAY_W'(29) : DAY_W'(28);
         default: n = DAY_W'(31);
      endcase
      return n;
   endfunction

endpackage

@@ hw/rtl/cma_datapath.sv @@
// Datapath: date/time registers, minute budget and one-step increment logic.
module cma_datapath (
   input  logic                    clock,
   input  cma_pkg::cma_req_type    req_data,
   input  cma_pkg::cma_cmd_type    cmd,
   output cma_pkg::cma_status_type status,
   output cma_pkg::cma_rsp_type    rsp_data
);

   logic [cma_pkg::ADD_W-1:0]   rem_ff,  rem_in;
   logic [cma_pkg::YEAR_W-1:0]  yr_ff,   yr_in;
   logic [cma_pkg::MONTH_W-1:0] mo_ff,   mo_in;
   logic [cma_pkg::DAY_W-1:0]   da_ff,   da_in;
   logic [cma_pkg::HOUR_W-1:0]  hr_ff,   hr_in;
   logic [cma_pkg::MIN_W-1:0]   mi_ff,   mi_in;
   logic [cma_pkg::SEC_W-1:0]   sec_ff,  sec_in;
   logic [cma_pkg::WDAY_W-1:0]  wd_ff,   wd_in;

   logic [cma_pkg::MIN_W:0]  mi_plus;
   logic [cma_pkg::HOUR_W:0] hr_plus;
   logic                     mi_wrap;
   logic                     hr_wrap;
   logic                     month_end;
   logic                     hour_tick;
   logic                     day_tick;

   // Form the carries of a single increment
   assign mi_plus   = {1'b0, mi_ff} + (cma_pkg::MIN_W+1)'(1);
   assign hr_plus   = {1'b0, hr_ff} + (cma_pkg::HOUR_W+1)'(1);
   assign mi_wrap   = mi_plus > cma_pkg::MINUTE_MAX;
   assign hr_wrap   = hr_plus > cma_pkg::HOUR_MAX;
   assign month_end = da_ff >= cma_pkg::cma_month_days(yr_ff, mo_ff);
   assign hour_tick = cmd.step_hour | (cmd.step_minute & mi_wrap);
   assign day_tick  = hour_tick & hr_wrap;

   // Load a new beat or advance by one hour or one minute
   always_comb begin
      rem_in = rem_ff;
      yr_in  = yr_ff;
      mo_in  = mo_ff;
      da_in  = da_ff;
      hr_in  = hr_ff;
      mi_in  = mi_ff;
      sec_in = sec_ff;
      wd_in  = wd_ff;
      if (cmd.load) begin
         rem_in = req_data.minutes_to_add;
         yr_in  = req_data.year_in;
         mo_in  = req_data.month_in;
         da_in  = req_data.day_in;
         hr_in  = req_data.hour_in;
         mi_in  = req_data.minute_in;
         sec_in = req_data.second_in;
         wd_in  = req_data.weekday_in;
      end else begin
         if (cmd.step_hour) begin
            rem_in = rem_ff - cma_pkg::HOUR_MINUTES;
         end
         if (cmd.step_minute) begin
            rem_in = rem_ff - cma_pkg::ADD_W'(1);
            mi_in  = mi_wrap ? '0 : mi_plus[cma_pkg::MIN_W-1:0];
         end
         if (hour_tick) begin
            hr_in = hr_wrap ? '0 : hr_plus[cma_pkg::HOUR_W-1:0];
         end
         // Roll the date over at the end of the month and year
         if (day_tick) begin
            if (month_end) begin
               da_in = cma_pkg::FIRST_DAY;
               if (mo_ff >= cma_pkg::MONTH_DEC) begin
                  mo_in = cma_pkg::MONTH_JAN;
                  yr_in = yr_ff + cma_pkg::YEAR_W'(1);
               end else begin
                  mo_in = mo_ff + cma_pkg::MONTH_W'(1);
               end
            end else begin
               da_in = da_ff + cma_pkg::DAY_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      yr_ff  <= yr_in;
      mo_ff  <= mo_in;
      da_ff  <= da_in;
      hr_ff  <= hr_in;
      mi_ff  <= mi_in;
      sec_ff <= sec_in;
      wd_ff  <= wd_in;
   end

   // Report the remaining budget
   assign status.rem_ge_hour = rem_ff >= cma_pkg::HOUR_MINUTES;
   assign status.rem_zero    = rem_ff == '0;

   assign rsp_data.year_out    = yr_ff;
   assign rsp_data.month_out   = mo_ff;
   assign rsp_data.day_out     = da_ff;
   assign rsp_data.hour_out    = hr_ff;
   assign rsp_data.minute_out  = mi_ff;
   assign rsp_data.second_out  = sec_ff;
   assign rsp_data.weekday_out = wd_ff;

endmodule

@@ hw/rtl/cma_controller.sv @@
// Controller: sequences whole-hour steps, then minute steps, then the result strobe.
module cma_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  cma_pkg::cma_status_type status,
   output cma_pkg::cma_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   cma_pkg::cma_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cma_pkg::ST_IDLE: begin
            if (start) begin
               state_in = cma_pkg::ST_HOURS;
            end
         end
         cma_pkg::ST_HOURS: begin
            if (!status.rem_ge_hour) begin
               state_in = cma_pkg::ST_MINUTES;
            end
         end
         cma_pkg::ST_MINUTES: begin
            if (status.rem_zero) begin
               state_in = cma_pkg::ST_DONE;
            end
         end
         cma_pkg::ST_DONE: begin
            state_in = cma_pkg::ST_IDLE;
         end
         default: begin
            state_in = cma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         cma_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         cma_pkg::ST_HOURS: begin
            cmd.step_hour = status.rem_ge_hour;
         end
         cma_pkg::ST_MINUTES: begin
            cmd.step_minute = !status.rem_zero;
         end
         cma_pkg::ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ hw/rtl/calendar_minutes_adder.sv @@
// Calendar minutes adder top level: advances a date and time by a number of minutes.
//
// A request beat is taken when start is high and busy is low. The block then
// advances the date one whole hour per cycle while 60 or more minutes remain,
// and one minute per cycle for the rest, rolling over hour, day, month and the
// year within the four-year cycle (year 0 has a 29-day February). When the
// steps are done, the result appears on rsp_data with rsp_strobe high for
// exactly one cycle; the receiver cannot stall it and must take it in that
// cycle. busy drops the cycle after the strobe, so a new request is taken
// only once the current one is finished. Seconds and weekday are copied
// through.
module calendar_minutes_adder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cma_pkg::cma_req_type req_data,
   output logic                 rsp_strobe,
   output cma_pkg::cma_rsp_type rsp_data
);

   cma_pkg::cma_cmd_type    cmd;
   cma_pkg::cma_status_type status;

   cma_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   cma_datapath u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
